### hdl/qrs_pkg.sv
// Package for the quadratic root solver: word sizes, pipeline depths,
// result codes and the request, result and pipeline stage structs.
// No dependencies; every other file of the block uses it.
package qrs_pkg;

  localparam int unsigned W     = 32;
  localparam int unsigned F     = 16;
  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  // Discriminant magnitude: b*b + 4*|a*c| stays below 2^(2W+1).
  localparam int unsigned DW        = 2 * W + 1;
  localparam int unsigned SQ_PER    = 3;
  localparam int unsigned SQ_STAGES = ((DW + 1) / 2 + SQ_PER - 1) / SQ_PER;
  localparam int unsigned SW        = SQ_STAGES * SQ_PER;
  localparam int unsigned RADW      = 2 * SW;
  localparam int unsigned REMW      = SW + 2;

  // Signed numerator of a division and the dividend built from it.
  localparam int unsigned NW         = SW + 3;
  localparam int unsigned QW         = NW + F;
  localparam int unsigned DENW       = W + 1;
  localparam int unsigned DIV_PER    = 3;
  localparam int unsigned DIV_STAGES = (QW + DIV_PER - 1) / DIV_PER;
  localparam int unsigned QWP        = DIV_STAGES * DIV_PER;

  localparam int unsigned THW  = TOL_W + F;
  localparam int unsigned CMPW = (DW > THW) ? DW : THW;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned LATENCY = SQ_STAGES + DIV_STAGES + 6;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;
  } req_t;

  typedef struct packed {
    logic signed [W-1:0] first_root;
    logic signed [W-1:0] second_root;
    logic [1:0]          root_count;
  } rsp_t;

  // Per-equation data that rides along the square root stages.
  typedef struct packed {
    logic signed [W-1:0] b;
    logic signed [W-1:0] c;
    logic [W-1:0]        ma;
    logic [W-1:0]        mb;
    logic                a_neg;
    logic                b_neg;
    logic                quad;
    logic                r1_on;
    logic [1:0]          cnt;
  } sd_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [SW-1:0]   res;
  } sq_t;

  // One division lane: dividend bits shift out at the top while quotient
  // bits shift in at the bottom.
  typedef struct packed {
    logic [QWP-1:0]  nq;
    logic [DENW-1:0] rem;
    logic [DENW-1:0] den;
    logic            neg;
    logic            keep;
    logic [1:0]      cnt;
  } dv_t;

endpackage

### hdl/qrs_front.sv
// Front end of the quadratic root solver: magnitudes and zero tests,
// the two products, the discriminant and the classification of the case.
// Depends on qrs_pkg.
module qrs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  qrs_pkg::req_t               req_i,
  input  logic [qrs_pkg::TOL_W-1:0]   tol_i,
  output logic                        valid_o,
  output qrs_pkg::sd_t                side_o,
  output qrs_pkg::sq_t                sq_o
);

  localparam int unsigned W    = qrs_pkg::W;
  localparam int unsigned F    = qrs_pkg::F;
  localparam int unsigned DW   = qrs_pkg::DW;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned CMPW = qrs_pkg::CMPW;
  localparam int unsigned RADW = qrs_pkg::RADW;
  localparam int unsigned REMW = qrs_pkg::REMW;
  localparam int unsigned SW   = qrs_pkg::SW;

  logic v1_q, v2_q, v3_q, v4_q;
  qrs_pkg::sd_t s1_d, s1_q, s2_q, s3_q, s4_d, s4_q;
  logic [W-1:0] mc1_d, mc1_q;
  logic bz1_d, bz1_q, cz1_d, cz1_q, bz2_q, cz2_q, bz3_q, cz3_q;
  logic cneg1_q, cneg2_q;
  logic [PW-1:0] b2_d, b2_q, ac2_d, ac2_q;
  logic [DW-1:0] b2w, ac4w, dmag3_d, dmag3_q;
  logic dneg3_d, dneg3_q;
  logic le;
  qrs_pkg::sq_t sq4_d, sq4_q;

  always_comb begin
    s1_d = '0;
    s1_d.b = req_i.coef_b;
    s1_d.c = req_i.coef_c;
    s1_d.a_neg = req_i.coef_a[W-1];
    s1_d.b_neg = req_i.coef_b[W-1];
    s1_d.ma = req_i.coef_a[W-1] ? W'(-req_i.coef_a) : W'(req_i.coef_a);
    s1_d.mb = req_i.coef_b[W-1] ? W'(-req_i.coef_b) : W'(req_i.coef_b);
    mc1_d   = req_i.coef_c[W-1] ? W'(-req_i.coef_c) : W'(req_i.coef_c);
    s1_d.quad = s1_d.ma > W'(tol_i);
    bz1_d = s1_d.mb <= W'(tol_i);
    cz1_d = mc1_d <= W'(tol_i);
  end

  assign b2_d  = PW'(s1_q.mb) * PW'(s1_q.mb);
  assign ac2_d = PW'(s1_q.ma) * PW'(mc1_q);

  always_comb begin
    b2w  = DW'(b2_q);
    ac4w = DW'(ac2_q) << 2;
    dneg3_d = 1'b0;
    if (s2_q.a_neg != cneg2_q) begin
      dmag3_d = b2w + ac4w;
    end else if (b2w >= ac4w) begin
      dmag3_d = b2w - ac4w;
    end else begin
      dmag3_d = ac4w - b2w;
      dneg3_d = 1'b1;
    end
  end

  always_comb begin
    le = CMPW'(dmag3_q) <= (CMPW'(tol_i) << F);
    s4_d = s3_q;
    if (s3_q.quad) begin
      if (dneg3_q && !le) begin
        s4_d.cnt = qrs_pkg::CNT_NONE;
      end else if (le) begin
        s4_d.cnt = qrs_pkg::CNT_ONE;
      end else begin
        s4_d.cnt = qrs_pkg::CNT_TWO;
      end
      s4_d.r1_on = !(dneg3_q && !le);
    end else begin
      if (!bz3_q) begin
        s4_d.cnt = qrs_pkg::CNT_ONE;
      end else if (!cz3_q) begin
        s4_d.cnt = qrs_pkg::CNT_NONE;
      end else begin
        s4_d.cnt = qrs_pkg::CNT_INF;
      end
      // With c near zero the linear root is exactly zero.
      s4_d.r1_on = !bz3_q && !cz3_q;
    end
    sq4_d.rad = RADW'(dmag3_q);
    sq4_d.rem = REMW'(0);
    sq4_d.res = SW'(0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    mc1_q   <= mc1_d;
    bz1_q   <= bz1_d;
    cz1_q   <= cz1_d;
    cneg1_q <= req_i.coef_c[W-1];
    s2_q    <= s1_q;
    b2_q    <= b2_d;
    ac2_q   <= ac2_d;
    bz2_q   <= bz1_q;
    cz2_q   <= cz1_q;
    cneg2_q <= cneg1_q;
    s3_q    <= s2_q;
    bz3_q   <= bz2_q;
    cz3_q   <= cz2_q;
    dmag3_q <= dmag3_d;
    dneg3_q <= dneg3_d;
    s4_q    <= s4_d;
    sq4_q   <= sq4_d;
  end

  assign valid_o = v4_q;
  assign side_o  = s4_q;
  assign sq_o    = sq4_q;

endmodule

### hdl/qrs_sqrt_stage.sv
// One stage of the digit-by-digit square root: a few radicand bit pairs
// per stage, with the equation's side data carried along.
// Depends on qrs_pkg.
module qrs_sqrt_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  qrs_pkg::sq_t sq_i,
  input  qrs_pkg::sd_t side_i,
  output logic         valid_o,
  output qrs_pkg::sq_t sq_o,
  output qrs_pkg::sd_t side_o
);

  localparam int unsigned SW   = qrs_pkg::SW;
  localparam int unsigned RADW = qrs_pkg::RADW;
  localparam int unsigned REMW = qrs_pkg::REMW;

  logic valid_q;
  qrs_pkg::sq_t sq_d, sq_q;
  qrs_pkg::sd_t side_q;
  logic [REMW-1:0] t, trial;

  // The remainder never exceeds twice the partial root, so its top two
  // bits are zero before each shift.
  always_comb begin
    sq_d = sq_i;
    t = '0;
    trial = '0;
    for (int k = 0; k < qrs_pkg::SQ_PER; k++) begin
      t     = {sq_d.rem[REMW-3:0], sq_d.rad[RADW-1 -: 2]};
      trial = {sq_d.res, 2'b01};
      sq_d.rad = sq_d.rad << 2;
      if (t >= trial) begin
        sq_d.rem = t - trial;
        sq_d.res = {sq_d.res[SW-2:0], 1'b1};
      end else begin
        sq_d.rem = t;
        sq_d.res = {sq_d.res[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign side_o  = side_q;

endmodule

### hdl/qrs_div_stage.sv
// One stage of a restoring divider lane: a few quotient bits per stage.
// Depends on qrs_pkg.
module qrs_div_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  qrs_pkg::dv_t dv_i,
  output logic         valid_o,
  output qrs_pkg::dv_t dv_o
);

  localparam int unsigned QWP  = qrs_pkg::QWP;
  localparam int unsigned DENW = qrs_pkg::DENW;

  logic valid_q;
  qrs_pkg::dv_t dv_d, dv_q;
  logic [DENW:0] t;
  logic qbit;

  always_comb begin
    dv_d = dv_i;
    t = '0;
    qbit = 1'b0;
    for (int k = 0; k < qrs_pkg::DIV_PER; k++) begin
      t = {dv_d.rem, dv_d.nq[QWP-1]};
      qbit = t >= {1'b0, dv_d.den};
      if (qbit) begin
        dv_d.rem = DENW'(t - {1'b0, dv_d.den});
      end else begin
        dv_d.rem = DENW'(t);
      end
      dv_d.nq = {dv_d.nq[QWP-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  assign valid_o = valid_q;
  assign dv_o    = dv_q;

endmodule

### hdl/quadratic_root_solver.sv
// Pipelined solver for a*x^2 + b*x + c = 0 in signed Q16.16. A request is
// taken in every cycle (busy_o stays low) and its result appears on rsp_o
// with a one-cycle done_o strobe, in request order; the depth is set by
// the 11 square root stages and the 18 stages of the two parallel divider
// lanes, three bits per stage. The receiver cannot stall,
// so results must be captured when done_o is high. zero_tolerance may be
// written only while no request is in flight.
// Depends on qrs_pkg, qrs_front, qrs_sqrt_stage and qrs_div_stage.
module quadratic_root_solver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  qrs_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic [qrs_pkg::TOL_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output qrs_pkg::rsp_t             rsp_o
);

  localparam int unsigned W     = qrs_pkg::W;
  localparam int unsigned F     = qrs_pkg::F;
  localparam int unsigned SW    = qrs_pkg::SW;
  localparam int unsigned REMW  = qrs_pkg::REMW;
  localparam int unsigned NW    = qrs_pkg::NW;
  localparam int unsigned QW    = qrs_pkg::QW;
  localparam int unsigned QWP   = qrs_pkg::QWP;
  localparam int unsigned DENW  = qrs_pkg::DENW;
  localparam int unsigned SQN   = qrs_pkg::SQ_STAGES;
  localparam int unsigned DVN   = qrs_pkg::DIV_STAGES;

  logic [qrs_pkg::TOL_W-1:0] tol_q;

  logic         sq_v  [SQN+1];
  qrs_pkg::sq_t sq_dt [SQN+1];
  qrs_pkg::sd_t sq_sd [SQN+1];

  logic         d1_v [DVN+1];
  qrs_pkg::dv_t d1_dt [DVN+1];
  logic         d2_v [DVN+1];
  qrs_pkg::dv_t d2_dt [DVN+1];

  qrs_pkg::sq_t sq_l;
  qrs_pkg::sd_t sd_l;
  logic [SW:0] s_w;
  logic signed [NW-1:0] s_sg, nb, nc, num1, num2;
  logic [DENW-1:0] den;
  logic den_neg;
  logic [NW-2:0] mag1, mag2;
  logic nv_q;
  qrs_pkg::dv_t n1_d, n1_q, n2_d, n2_q;

  logic done_q;
  qrs_pkg::rsp_t rsp_d, rsp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qrs_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  qrs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (req_i),
    .tol_i   (tol_q),
    .valid_o (sq_v[0]),
    .side_o  (sq_sd[0]),
    .sq_o    (sq_dt[0])
  );

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    qrs_sqrt_stage u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .sq_i    (sq_dt[i]),
      .side_i  (sq_sd[i]),
      .valid_o (sq_v[i+1]),
      .sq_o    (sq_dt[i+1]),
      .side_o  (sq_sd[i+1])
    );
  end

  // Rounded square root, numerators and dividends of both lanes.
  always_comb begin
    sq_l = sq_dt[SQN];
    sd_l = sq_sd[SQN];
    s_w  = (SW+1)'(sq_l.res) + (SW+1)'(sq_l.rem > REMW'(sq_l.res));
    s_sg = $signed({2'b00, s_w});
    nb   = -$signed({{(NW-W){sd_l.b[W-1]}}, sd_l.b});
    nc   = -$signed({{(NW-W){sd_l.c[W-1]}}, sd_l.c});
    if (sd_l.quad) begin
      den     = {sd_l.ma, 1'b0};
      den_neg = sd_l.a_neg;
      num1    = (sd_l.cnt == qrs_pkg::CNT_TWO) ? nb - s_sg : nb;
    end else begin
      den     = {1'b0, sd_l.mb};
      den_neg = sd_l.b_neg;
      num1    = nc;
    end
    num2 = nb + s_sg;
    mag1 = num1[NW-1] ? (NW-1)'(-num1) : (NW-1)'(num1);
    mag2 = num2[NW-1] ? (NW-1)'(-num2) : (NW-1)'(num2);

    n1_d.nq   = QWP'((QW'(mag1) << F) + QW'(den >> 1));
    n1_d.rem  = '0;
    n1_d.den  = den;
    n1_d.neg  = num1[NW-1] != den_neg;
    n1_d.keep = sd_l.r1_on;
    n1_d.cnt  = sd_l.cnt;

    n2_d.nq   = QWP'((QW'(mag2) << F) + QW'(den >> 1));
    n2_d.rem  = '0;
    n2_d.den  = den;
    n2_d.neg  = num2[NW-1] != den_neg;
    n2_d.keep = sd_l.cnt == qrs_pkg::CNT_TWO;
    n2_d.cnt  = sd_l.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else begin
      nv_q <= sq_v[SQN];
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d;
    n2_q <= n2_d;
  end

  assign d1_v[0]  = nv_q;
  assign d1_dt[0] = n1_q;
  assign d2_v[0]  = nv_q;
  assign d2_dt[0] = n2_q;

  for (genvar j = 0; j < DVN; j++) begin : g_div
    qrs_div_stage u_div1 (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d1_v[j]),
      .dv_i    (d1_dt[j]),
      .valid_o (d1_v[j+1]),
      .dv_o    (d1_dt[j+1])
    );
    qrs_div_stage u_div2 (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d2_v[j]),
      .dv_i    (d2_dt[j]),
      .valid_o (d2_v[j+1]),
      .dv_o    (d2_dt[j+1])
    );
  end

  // Saturate the quotient, apply the sign and clear an absent root.
  function automatic logic [W-1:0] finish_root(qrs_pkg::dv_t d);
    logic [W-1:0] lim;
    logic [W-1:0] m;
    lim = d.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    m = (d.nq > QWP'(lim)) ? lim : d.nq[W-1:0];
    if (d.neg) begin
      m = -m;
    end
    if (!d.keep) begin
      m = '0;
    end
    return m;
  endfunction

  always_comb begin
    rsp_d.first_root  = finish_root(d1_dt[DVN]);
    rsp_d.second_root = finish_root(d2_dt[DVN]);
    rsp_d.root_count  = d1_dt[DVN].cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d1_v[DVN];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(qrs_pkg::LATENCY) done_o)
    else $error("result strobe missing after fixed latency");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.root_count != qrs_pkg::CNT_TWO |-> rsp_o.second_root == '0)
    else $error("second root nonzero without two roots");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.root_count == qrs_pkg::CNT_NONE ||
               rsp_o.root_count == qrs_pkg::CNT_INF) |-> rsp_o.first_root == '0)
    else $error("first root nonzero without a root");
`endif

endmodule

### test/qrs_checker.sv
// Checker for the quadratic root solver: predicts each result from the accepted
// request and the current zero tolerance, and compares results in order.
// Depends on qrs_pkg for the request and result structs.
`timescale 1ns / 1ps

module qrs_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  qrs_pkg::req_t             req_i,
  input  logic                      cfg_we_i,
  input  logic [qrs_pkg::TOL_W-1:0] cfg_wdata_i,
  input  logic                      done_i,
  input  qrs_pkg::rsp_t             rsp_i,
  output int                        errors_o,
  output int                        outstanding_o,
  output int                        checked_o,
  output int                        count_seen_o [4]
);

  logic [qrs_pkg::TOL_W-1:0] tol_q;
  qrs_pkg::rsp_t             roots_q[$];

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // Square root of a 128-bit value, rounded to the nearest integer.
  function automatic logic [63:0] sqrt_round(logic [127:0] d);
    logic [127:0] rem, res, bt, t;
    rem = d;
    res = '0;
    bt  = 128'd1 << 126;
    while (bt != 0 && bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      t = res + bt;
      if (rem >= t) begin
        rem = rem - t;
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (rem > res) res = res + 1;
    return res[63:0];
  endfunction

  // Q16.16 quotient num / (+-den), rounded half away from zero, saturated.
  function automatic logic [31:0] div_round(longint num, logic [63:0] den, bit den_neg);
    bit           neg;
    logic [63:0]  lim, mn, m;
    logic [127:0] n, q;
    neg = (num < 0) != den_neg;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (den == 0) return '0;
    mn = (num < 0) ? -num : num;
    n  = ({64'd0, mn} << qrs_pkg::F) + {65'd0, den[63:1]};
    q  = n / {64'd0, den};
    m  = (q > {64'd0, lim}) ? lim : q[63:0];
    return neg ? -m[31:0] : m[31:0];
  endfunction

  function automatic qrs_pkg::rsp_t solve_equation(qrs_pkg::req_t r,
                                                   logic [qrs_pkg::TOL_W-1:0] tol);
    qrs_pkg::rsp_t o;
    logic [31:0]   ma, mb, mc;
    logic [63:0]   den2a;
    logic [127:0]  b2, ac4, dmag, thr;
    bit            dneg, bz, cz;
    longint        bl, cl, s;
    ma = mag32(r.coef_a);
    mb = mag32(r.coef_b);
    mc = mag32(r.coef_c);
    bl = r.coef_b;
    cl = r.coef_c;
    den2a = {31'd0, ma, 1'b0};
    o  = '0;
    if (ma > tol) begin
      b2   = {96'd0, mb} * {96'd0, mb};
      ac4  = ({96'd0, ma} * {96'd0, mc}) << 2;
      dneg = 0;
      if (r.coef_a[31] != r.coef_c[31]) dmag = b2 + ac4;
      else if (b2 >= ac4) dmag = b2 - ac4;
      else begin
        dmag = ac4 - b2;
        dneg = 1;
      end
      thr = {112'd0, tol} << qrs_pkg::F;
      if (dneg && dmag > thr) begin
        o.root_count = qrs_pkg::CNT_NONE;
      end else if (dmag <= thr) begin
        o.first_root = div_round(-bl, den2a, r.coef_a[31]);
        o.root_count = qrs_pkg::CNT_ONE;
      end else begin
        s = sqrt_round(dmag);
        o.first_root  = div_round(-bl - s, den2a, r.coef_a[31]);
        o.second_root = div_round(-bl + s, den2a, r.coef_a[31]);
        o.root_count  = qrs_pkg::CNT_TWO;
      end
    end else begin
      bz = mb <= tol;
      cz = mc <= tol;
      if (!bz && !cz) begin
        o.first_root = div_round(-cl, {32'd0, mb}, r.coef_b[31]);
        o.root_count = qrs_pkg::CNT_ONE;
      end else if (!bz) o.root_count = qrs_pkg::CNT_ONE;
      else if (!cz) o.root_count = qrs_pkg::CNT_NONE;
      else o.root_count = qrs_pkg::CNT_INF;
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    qrs_pkg::rsp_t want;
    if (!rst_ni) begin
      tol_q = qrs_pkg::TOL_RESET;
      roots_q.delete();
      errors_o = 0;
      checked_o = 0;
      outstanding_o = 0;
      foreach (count_seen_o[i]) count_seen_o[i] = 0;
    end else begin
      if (cfg_we_i) tol_q = cfg_wdata_i;
      if (start_i && !busy_i) roots_q.push_back(solve_equation(req_i, tol_q));
      if (done_i) begin
        if (roots_q.size() == 0) begin
          report("unexpected result", 32'(rsp_i.root_count), 32'd0);
        end else begin
          want = roots_q.pop_front();
          checked_o++;
          count_seen_o[want.root_count]++;
          if (rsp_i.root_count !== want.root_count)
            report("root_count", 32'(rsp_i.root_count), 32'(want.root_count));
          if (rsp_i.first_root !== want.first_root)
            report("first_root", rsp_i.first_root, want.first_root);
          if (rsp_i.second_root !== want.second_root)
            report("second_root", rsp_i.second_root, want.second_root);
        end
      end
      outstanding_o = roots_q.size();
    end
  end

endmodule

### test/tb.sv
// Top of the quadratic root solver testbench: clock, reset, request and
// tolerance stimulus, and the verdict. Depends on qrs_pkg, qrs_checker and
// the solver RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_CYCLES = 300000;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      start = 0;
  logic                      busy;
  qrs_pkg::req_t             req = '0;
  logic                      cfg_we = 0;
  logic [qrs_pkg::TOL_W-1:0] cfg_wdata = '0;
  logic                      done;
  qrs_pkg::rsp_t             rsp;
  int                        errors, outstanding, checked, cycles;
  int                        count_seen [4];
  logic [qrs_pkg::TOL_W-1:0] tol = qrs_pkg::TOL_RESET;
  bit                        no_gaps;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  quadratic_root_solver dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .req_i(req),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .done_o(done), .rsp_o(rsp)
  );

  qrs_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .req_i(req),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .done_i(done), .rsp_i(rsp),
    .errors_o(errors), .outstanding_o(outstanding), .checked_o(checked),
    .count_seen_o(count_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int q16(int whole);
    return whole <<< 16;
  endfunction

  function automatic int near_tol();
    return int'($urandom_range(0, 2 * tol)) - int'(tol);
  endfunction

  // Busy only changes at a rising edge, so it is sampled on the falling one.
  task automatic send(int a, int b, int c);
    int gap;
    start <= 1;
    req   <= '{coef_a: a, coef_b: b, coef_c: c};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    gap = 0;
    if (!no_gaps && $urandom_range(0, 9) > 6)
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (qrs_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [qrs_pkg::TOL_W-1:0] v);
    drain();
    tol = v;
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_request();
    int a, b, c, r1, r2, k;
    case ($urandom_range(0, 6))
      0: begin
        a = $urandom; b = $urandom; c = $urandom;
      end
      1: begin
        a = int'($urandom_range(0, 2 ** 20)) - 2 ** 19;
        b = int'($urandom_range(0, 2 ** 22)) - 2 ** 21;
        c = int'($urandom_range(0, 2 ** 22)) - 2 ** 21;
      end
      2: begin
        a = near_tol(); b = $urandom; c = $urandom;
      end
      3: begin
        a = near_tol(); b = near_tol(); c = ($urandom_range(0, 1)) ? near_tol() : $urandom;
      end
      default: begin
        // Built from chosen roots, so the discriminant is often exactly zero.
        k  = int'($urandom_range(1, 8)) * (($urandom_range(0, 1)) ? 1 : -1);
        r1 = int'($urandom_range(0, 40)) - 20;
        r2 = ($urandom_range(0, 2) == 0) ? r1 : int'($urandom_range(0, 40)) - 20;
        a  = q16(k);
        b  = q16(-k * (r1 + r2)) + (($urandom_range(0, 3) == 0) ? near_tol() : 0);
        c  = q16(k * r1 * r2);
      end
    endcase
    send(a, b, c);
  endtask

  initial begin
    no_gaps = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed requests at the reset tolerance.
    send(q16(1), q16(-3), q16(2));
    send(q16(-1), q16(3), q16(-2));
    send(q16(1), q16(2), q16(1));
    send(q16(1), 0, q16(1));
    send(0, q16(2), q16(-4));
    send(0, q16(3), 0);
    send(0, 0, q16(5));
    send(0, 0, 0);
    send(66, -66, 66);
    send(67, 67, -67);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(1000, 32'h7fff_ffff, 32'h8000_0000);
    send(0, 67, 32'h7fff_ffff);
    send(0, -67, 32'h8000_0000);
    send(q16(1), 0, 0);
    send(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
    send(q16(2), q16(-1), -50);

    set_tolerance(0);
    send(1, 0, 0);
    send(0, 1, -1);
    send(0, 0, 1);
    send(0, 0, 0);
    send(1, 2, 1);
    for (int i = 0; i < 150; i++) begin
      if (i % 50 == 0) no_gaps = !no_gaps;
      random_request();
    end

    set_tolerance(16'hffff);
    no_gaps = 0;
    for (int i = 0; i < 150; i++) random_request();

    for (int p = 0; p < 3; p++) begin
      set_tolerance($urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)));
      no_gaps = (p == 1);
      for (int i = 0; i < 100; i++) random_request();
    end

    drain();
    $display("%0d equations checked at several tolerances; results with no root %0d,",
             checked, count_seen[qrs_pkg::CNT_NONE]);
    $display("one root %0d, two roots %0d, infinitely many %0d",
             count_seen[qrs_pkg::CNT_ONE], count_seen[qrs_pkg::CNT_TWO],
             count_seen[qrs_pkg::CNT_INF]);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
